// ===== rtl/core/argbpt_pkg.sv =====
// Shared types, constants and arithmetic helpers for the ARGB polyphase
// tap accumulator. No dependencies; used by argbpt_lane and the top level.
package argbpt_pkg;

  localparam int NUM_CH      = 4;
  localparam int CH_W        = 16;
  localparam int BYTE_W      = 8;
  localparam int HORIZ_SHIFT = 7;
  localparam int VERT_SHIFT  = 3;
  localparam int PIX_MAX     = 255;

  // pass_select codes
  localparam logic PASS_HORIZ = 1'b0;
  localparam logic PASS_VERT  = 1'b1;

  // Per-lane control, one set per cycle from the tap stage
  typedef struct packed {
    logic advance;  // tap word leaves the tap stage this cycle
    logic last;     // final tap of the output pixel
    logic vert;     // vertical pass in force
  } lane_ctrl_t;

  typedef logic signed [CH_W-1:0] chan_t;

  // Clamp a 17-bit signed sum to the 16-bit signed range
  function automatic chan_t sat16(input logic signed [CH_W:0] s);
    logic signed [CH_W:0] max_v;
    logic signed [CH_W:0] min_v;
    max_v = {2'b00, {(CH_W-1){1'b1}}};
    min_v = {2'b11, {(CH_W-1){1'b0}}};
    if (s > max_v) begin
      sat16 = max_v[CH_W-1:0];
    end else if (s < min_v) begin
      sat16 = min_v[CH_W-1:0];
    end else begin
      sat16 = s[CH_W-1:0];
    end
  endfunction

  // Arithmetic shift right by VERT_SHIFT, then clamp to 0..PIX_MAX
  function automatic chan_t vert_finish(input chan_t s);
    logic signed [CH_W-VERT_SHIFT-1:0] q;
    q = s[CH_W-1:VERT_SHIFT];
    if (q < 0) begin
      vert_finish = '0;
    end else if (q > PIX_MAX) begin
      vert_finish = CH_W'(PIX_MAX);
    end else begin
      vert_finish = CH_W'(q);
    end
  endfunction

endpackage

// ===== rtl/core/argb_polyphase_tap_accumulator_top.sv =====
// Top level of the ARGB polyphase tap accumulator: tap register, four
// channel lanes and the result register. Depends on argbpt_pkg, argbpt_lane.
//
// Usage:
//   Input channel (in_valid / in_stall): one tap word per accepted cycle,
//   carrying a source pixel, a signed coefficient (16384 = 1.0) and a
//   last-tap mark. The block takes one word every cycle unless in_stall is high.
//   Result channel (out_valid / out_stall): one word per last tap, holding
//   the four channel sums (horizontal pass) or the sums shifted right by 3
//   and clamped to 0..255 (vertical pass).
//   Configuration (cfg_wr_en / cfg_wr_data): pass_select, written while idle.
//   An accepted last tap passes through the tap register, then the result
//   register.
//   Throughput is one tap word per cycle while the input is not stalled, set
//   by the single multiply-accumulate per lane in the tap stage.
//   Reset clears pass_select, the accumulators and both valid flags.
//   While the receiver stalls, the held result stays on the outputs; further
//   non-last taps keep accumulating, and the input stalls only when a new
//   last tap waits behind the held result.
module argb_polyphase_tap_accumulator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        in_tap_pixel,
  input  logic signed [15:0] in_tap_coeff,
  input  logic               in_last_tap,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_alpha,
  output logic signed [15:0] out_red,
  output logic signed [15:0] out_green,
  output logic signed [15:0] out_blue
);

  localparam int CW = argbpt_pkg::CH_W;
  localparam int BW = argbpt_pkg::BYTE_W;
  localparam int NC = argbpt_pkg::NUM_CH;

  logic                   pass_sel_r;
  logic                   s1_valid_r, s1_valid_nxt;
  logic [NC*CW-1:0]       s1_pixel_r;
  argbpt_pkg::chan_t      s1_coeff_r;
  logic                   s1_last_r;
  logic                   in_accept;
  logic                   advance;
  argbpt_pkg::lane_ctrl_t ctrl;
  argbpt_pkg::chan_t      chan_val [NC];
  argbpt_pkg::chan_t      lane_res [NC];
  logic                   out_valid_r, out_valid_nxt;
  argbpt_pkg::chan_t      out_data_r [NC];

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_sel_r <= argbpt_pkg::PASS_HORIZ;
    end else if (cfg_wr_en) begin
      pass_sel_r <= cfg_wr_data;
    end
  end

  // Tap stage handshake: a last tap waits only if the result register is held
  assign advance   = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Tap word register, payload only
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pixel_r <= in_tap_pixel;
      s1_coeff_r <= in_tap_coeff;
      s1_last_r  <= in_last_tap;
    end
  end

  assign ctrl.advance = advance;
  assign ctrl.last    = s1_last_r;
  assign ctrl.vert    = (pass_sel_r == argbpt_pkg::PASS_VERT);

  // Channel unpack (A,R,G,B order) and lanes
  for (genvar i = 0; i < NC; i++) begin : g_lane
    assign chan_val[i] = ctrl.vert
      ? s1_pixel_r[NC*CW-1-CW*i -: CW]
      : {1'b0, s1_pixel_r[NC*BW-1-BW*i -: BW], {argbpt_pkg::HORIZ_SHIFT{1'b0}}};

    argbpt_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .chan_val (chan_val[i]),
      .coeff    (s1_coeff_r),
      .result   (lane_res[i])
    );
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_data_r <= lane_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_alpha = out_data_r[0];
  assign out_red   = out_data_r[1];
  assign out_green = out_data_r[2];
  assign out_blue  = out_data_r[3];

  // Checks
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("valid flags not cleared by reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r && out_stall))
    else $error("input stalled without a held result blocking a last tap");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_last_r) |=> out_valid_r)
    else $error("last tap did not load the result register");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r[0])))
    else $error("held result dropped or overwritten");

  a_tap_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> (s1_valid_r && $stable(s1_coeff_r)))
    else $error("tap word lost while waiting");

endmodule

// ===== rtl/core/argbpt_lane.sv =====
// One color channel lane: 16x16 signed multiply, saturating accumulate,
// vertical-pass finish. Depends on argbpt_pkg.
module argbpt_lane (
  input  logic                  clk,
  input  logic                  rst_n,
  input  argbpt_pkg::lane_ctrl_t ctrl,
  input  argbpt_pkg::chan_t     chan_val,
  input  argbpt_pkg::chan_t     coeff,
  output argbpt_pkg::chan_t     result
);

  logic signed [2*argbpt_pkg::CH_W-1:0] prod;
  argbpt_pkg::chan_t                    prod_hi;
  argbpt_pkg::chan_t                    sum_sat;
  argbpt_pkg::chan_t                    acc_r;
  argbpt_pkg::chan_t                    acc_nxt;

  // High half of the product is floor(prod / 65536)
  assign prod    = chan_val * coeff;
  assign prod_hi = prod[2*argbpt_pkg::CH_W-1:argbpt_pkg::CH_W];

  // Saturating add into the accumulator
  assign sum_sat = argbpt_pkg::sat16(
    {acc_r[argbpt_pkg::CH_W-1], acc_r} + {prod_hi[argbpt_pkg::CH_W-1], prod_hi});

  // Result format follows the pass at the last tap
  assign result = ctrl.vert ? argbpt_pkg::vert_finish(sum_sat) : sum_sat;

  // Accumulator clears after the last tap
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.advance) begin
      acc_nxt = ctrl.last ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule
